FILE: hw/rtl/pvm_pkg.sv
// Shared types and constants for the PCM voice mixer.
`timescale 1ns / 1ps
package pvm_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_TICK = 2'd2,
    MODE_STOP = 2'd3
  } mode_e;

  localparam int unsigned CfgFirstShared = 0;
  localparam int unsigned CfgStealId     = 1;

  localparam logic [4:0]  AnyVoice    = 5'd16;
  localparam int          RateDefault = 22050;
  localparam int          RateMin     = 100;
  localparam int          RateMax     = 100000;
  localparam logic [8:0]  UnityAbove  = 9'd250;

  // ceil(2^38 / 11025): (rate * StepRecip) >> StepShift equals (rate << 8) / 22050
  // for every rate up to well past RateMax.
  localparam logic [24:0] StepRecip = 25'd24932237;
  localparam int unsigned StepShift = 31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       play_setup;  // latch request fields and the clamped rate
    logic       step_calc;   // register the step from the reciprocal multiply
    logic       play_commit; // apply the play decision
    logic       tick_clear;  // clear the accumulator
    logic       tick_read;   // issue memory read for the current voice
    logic       tick_acc;    // accumulate and advance the current voice
    logic       tick_done;   // saturate the sum into the result
    logic       stop_all;    // deactivate voices 1 and up
    logic       load_write;  // write one sample word
  } pvm_cmd_t;

  typedef struct packed {
    logic voice_last;
  } pvm_stat_t;

endpackage

FILE: hw/rtl/pvm_ctrl.sv
// Sequencer for the PCM voice mixer.
`timescale 1ns / 1ps
module pvm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        mode_i,
  input  pvm_pkg::pvm_stat_t stat_i,
  output pvm_pkg::pvm_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_COMMIT, S_READ, S_ACC, S_SAT
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            unique case (pvm_pkg::mode_e'(mode_i))
              pvm_pkg::MODE_PLAY: state_q <= S_STEP;
              pvm_pkg::MODE_TICK: state_q <= S_READ;
              default:            done_q  <= 1'b1;
            endcase
          end
        end
        S_STEP:   state_q <= S_COMMIT;
        S_COMMIT: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        S_READ:   state_q <= S_ACC;
        S_ACC:    state_q <= stat_i.voice_last ? S_SAT : S_READ;
        S_SAT: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  logic idle_start;
  assign idle_start = (state_q == S_IDLE) && start_i;

  always_comb begin
    cmd_o             = '0;
    cmd_o.play_setup  = idle_start && (mode_i == pvm_pkg::MODE_PLAY);
    cmd_o.tick_clear  = idle_start && (mode_i == pvm_pkg::MODE_TICK);
    cmd_o.load_write  = idle_start && (mode_i == pvm_pkg::MODE_LOAD);
    cmd_o.stop_all    = idle_start && (mode_i == pvm_pkg::MODE_STOP);
    cmd_o.step_calc   = (state_q == S_STEP);
    cmd_o.play_commit = (state_q == S_COMMIT);
    cmd_o.tick_read   = (state_q == S_READ);
    cmd_o.tick_acc    = (state_q == S_ACC);
    cmd_o.tick_done   = (state_q == S_SAT);
  end

  assign busy_o = (state_q != S_IDLE) || done_q;
  assign done_o = done_q;

endmodule

FILE: hw/rtl/pvm_datapath.sv
// Voice state, sample memory, step multiplier and mix accumulator.
`timescale 1ns / 1ps
module pvm_datapath #(
  parameter int unsigned VOICE_COUNT         = 16,
  parameter int unsigned SAMPLE_MEMORY_WORDS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvm_pkg::pvm_cmd_t  cmd_i,
  output pvm_pkg::pvm_stat_t stat_o,
  input  logic [3:0]         first_shared_voice_i,
  input  logic [5:0]         steal_sample_id_i,
  input  logic [15:0]        address_i,
  input  logic signed [15:0] sample_word_i,
  input  logic [5:0]         sample_id_i,
  input  logic [16:0]        length_i,
  input  logic [7:0]         loop_count_i,
  input  logic signed [17:0] pitch_i,
  input  logic signed [15:0] pitch_offset_i,
  input  logic [15:0]        volume_i,
  input  logic [4:0]         voice_select_i,
  input  logic               modify_if_busy_i,
  output logic signed [15:0] mixed_sample_o,
  output logic [4:0]         voice_used_o,
  output logic               clipped_o
);

  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned AW = $clog2(SAMPLE_MEMORY_WORDS);
  localparam int unsigned SW = 11;

  // Sample memory
  logic signed [15:0] mem_q [SAMPLE_MEMORY_WORDS];
  logic signed [15:0] rd_q;
  logic [AW-1:0]      rd_addr;

  // Voice state
  logic [VOICE_COUNT-1:0] act_q;
  logic [5:0]  id_q    [VOICE_COUNT];
  logic [15:0] base_q  [VOICE_COUNT];
  logic [24:0] len_q   [VOICE_COUNT];
  logic [24:0] pos_q   [VOICE_COUNT];
  logic [SW-1:0] step_q [VOICE_COUNT];
  logic [8:0]  vol_q   [VOICE_COUNT];
  logic [7:0]  loops_q [VOICE_COUNT];

  // Request latch and step
  logic [5:0]  rid_q;
  logic [15:0] rbase_q;
  logic [16:0] rlen_q;
  logic [7:0]  rloops_q;
  logic [8:0]  rvol_q;
  logic [4:0]  rsel_q;
  logic        rmod_q;
  logic [16:0]   rrate_q;
  logic [SW-1:0] rstep_q;

  // Tick
  logic [VW-1:0]      vi_q;
  logic signed [20:0] sum_q;

  // Pitch preparation
  logic signed [18:0] rate;
  logic signed [18:0] rate_c;
  always_comb begin
    rate = (pitch_i == -18'sd1) ? 19'(pvm_pkg::RateDefault) : 19'(pitch_i);
    rate = rate + 19'(pitch_offset_i);
    rate_c = rate;
    if (rate > 19'(pvm_pkg::RateMax)) rate_c = 19'(pvm_pkg::RateMax);
    if (rate < 19'(pvm_pkg::RateMin)) rate_c = 19'(pvm_pkg::RateMin);
  end

  // Step = (rate << 8) / 22050 as a reciprocal multiply on the latched rate
  logic [41:0] step_prod;
  assign step_prod = 42'(rrate_q) * 42'(pvm_pkg::StepRecip);

  assign stat_o.voice_last = (vi_q == VW'(VOICE_COUNT - 1));

  // Voice selection
  logic          sel_fixed;
  logic [VW-1:0] fix_v;
  logic          free_hit, steal_hit;
  logic [VW-1:0] free_v, steal_v;
  always_comb begin
    sel_fixed = (rsel_q != pvm_pkg::AnyVoice) && (32'(rsel_q) < VOICE_COUNT);
    fix_v     = rsel_q[VW-1:0];
    free_hit = 1'b0; steal_hit = 1'b0;
    free_v = '0; steal_v = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (i >= int'(first_shared_voice_i)) begin
        if (!act_q[i]) begin
          free_hit = 1'b1; free_v = VW'(i);
        end
        if (id_q[i] == steal_sample_id_i) begin
          steal_hit = 1'b1; steal_v = VW'(i);
        end
      end
    end
  end

  // Mix of the current voice
  logic signed [24:0] prod;
  logic signed [16:0] contrib;
  logic [24:0]        pos_n;
  assign prod    = rd_q * $signed({1'b0, vol_q[vi_q]});
  assign contrib = (vol_q[vi_q] > pvm_pkg::UnityAbove) ? 17'(rd_q) : 17'(prod >>> 8);
  assign pos_n   = pos_q[vi_q] + 25'(step_q[vi_q]);

  assign rd_addr = AW'(32'(base_q[vi_q]) + 32'(pos_q[vi_q][24:8]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_write) mem_q[AW'(address_i)] <= sample_word_i;
    if (cmd_i.tick_read)  rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.play_setup) begin
      rid_q    <= sample_id_i;
      rbase_q  <= address_i;
      rlen_q   <= length_i;
      rloops_q <= loop_count_i;
      rvol_q   <= volume_i[15:7];
      rsel_q   <= voice_select_i;
      rmod_q   <= modify_if_busy_i;
      rrate_q  <= rate_c[16:0];
    end
    if (cmd_i.step_calc) rstep_q <= step_prod[pvm_pkg::StepShift +: SW];
  end

  logic          do_start, do_retune;
  logic [VW-1:0] tv;
  always_comb begin
    do_start = 1'b0; do_retune = 1'b0; tv = fix_v;
    if (sel_fixed) begin
      if (!act_q[fix_v]) do_start = 1'b1;
      else do_retune = rmod_q;
    end else if (free_hit) begin
      do_start = 1'b1; tv = free_v;
    end else if (steal_hit) begin
      do_start = 1'b1; tv = steal_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        id_q[i] <= '0; base_q[i] <= '0; len_q[i] <= '0; pos_q[i] <= '0;
        step_q[i] <= '0; vol_q[i] <= '0; loops_q[i] <= '0;
      end
      vi_q <= '0; sum_q <= '0;
      mixed_sample_o <= '0; voice_used_o <= pvm_pkg::AnyVoice; clipped_o <= 1'b0;
    end else begin
      if (cmd_i.play_setup || cmd_i.tick_clear || cmd_i.load_write || cmd_i.stop_all) begin
        mixed_sample_o <= '0; voice_used_o <= pvm_pkg::AnyVoice; clipped_o <= 1'b0;
      end
      if (cmd_i.stop_all) act_q[VOICE_COUNT-1:1] <= '0;
      if (cmd_i.play_commit && (do_start || do_retune)) begin
        vol_q[tv] <= rvol_q; step_q[tv] <= rstep_q; loops_q[tv] <= rloops_q;
        voice_used_o <= 5'(tv);
        if (do_start) begin
          id_q[tv] <= rid_q; base_q[tv] <= rbase_q; len_q[tv] <= {rlen_q, 8'd0};
          pos_q[tv] <= '0; act_q[tv] <= 1'b1;
        end
      end
      if (cmd_i.tick_clear) begin
        sum_q <= '0; vi_q <= '0;
      end
      if (cmd_i.tick_acc) begin
        vi_q <= stat_o.voice_last ? '0 : vi_q + VW'(1);
        if (act_q[vi_q]) begin
          sum_q <= sum_q + 21'(contrib);
          if (pos_n >= len_q[vi_q]) begin
            pos_q[vi_q] <= pos_n - len_q[vi_q];
            if (loops_q[vi_q] == 8'd0) act_q[vi_q] <= 1'b0;
            else loops_q[vi_q] <= loops_q[vi_q] - 8'd1;
          end else begin
            pos_q[vi_q] <= pos_n;
          end
        end
      end
      if (cmd_i.tick_done) begin
        if (sum_q > 21'sd32767) begin
          mixed_sample_o <= 16'sh7fff; clipped_o <= 1'b1;
        end else if (sum_q < -21'sd32768) begin
          mixed_sample_o <= -16'sd32768; clipped_o <= 1'b1;
        end else begin
          mixed_sample_o <= sum_q[15:0];
        end
      end
    end
  end

endmodule

FILE: hw/rtl/pcm_voice_mixer_core.sv
// Top level of the PCM voice mixer: config registers, sequencer and datapath.
`timescale 1ns / 1ps
// Usage: raise start with a beat while busy is low; exactly one result beat
// follows, flagged by done_o for one cycle, and it cannot be stalled. A load or
// stop goes straight to its result; a play request first registers the pitch
// step from a reciprocal multiply on the clamped rate, then commits, then gives
// the result; a tick does one memory read and one accumulate per voice, then
// saturation, then the result. busy stays high through the result cycle, so the
// next beat is taken in the cycle after the result. Config writes are taken any
// time but belong to idle periods. Sample memory has no reset; read only what
// was written.
module pcm_voice_mixer_core #(
  parameter int unsigned VOICE_COUNT         = 16,
  parameter int unsigned SAMPLE_MEMORY_WORDS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        address_i,
  input  logic signed [15:0] sample_word_i,
  input  logic [5:0]         sample_id_i,
  input  logic [16:0]        length_i,
  input  logic [7:0]         loop_count_i,
  input  logic signed [17:0] pitch_i,
  input  logic signed [15:0] pitch_offset_i,
  input  logic [15:0]        volume_i,
  input  logic [4:0]         voice_select_i,
  input  logic               modify_if_busy_i,
  output logic               done_o,
  output logic signed [15:0] mixed_sample_o,
  output logic [4:0]         voice_used_o,
  output logic               clipped_o
);

  logic [3:0] first_shared_q;
  logic [5:0] steal_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_shared_q <= 4'd10;
      steal_id_q     <= 6'd11;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        1'(pvm_pkg::CfgFirstShared): first_shared_q <= cfg_data_i[3:0];
        default:                     steal_id_q     <= cfg_data_i;
      endcase
    end
  end

  pvm_pkg::pvm_cmd_t  cmd;
  pvm_pkg::pvm_stat_t stat;
  logic               go;
  assign go = start && !busy;

  pvm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(go), .mode_i, .stat_i(stat), .cmd_o(cmd),
    .busy_o(busy), .done_o
  );

  pvm_datapath #(
    .VOICE_COUNT(VOICE_COUNT), .SAMPLE_MEMORY_WORDS(SAMPLE_MEMORY_WORDS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .first_shared_voice_i(first_shared_q), .steal_sample_id_i(steal_id_q),
    .address_i, .sample_word_i, .sample_id_i, .length_i, .loop_count_i,
    .pitch_i, .pitch_offset_i, .volume_i, .voice_select_i, .modify_if_busy_i,
    .mixed_sample_o, .voice_used_o, .clipped_o
  );

endmodule
